@@ rtl/rcl_pkg.sv @@
// shared constants, types and command/status structs for the row cluster legalizer
`timescale 1ns / 1ps
package rcl_pkg;

  localparam int MAX_CLUSTERS = 256;
  localparam int MAX_CELLS    = 1024;

  localparam int ADDR_W  = $clog2(MAX_CLUSTERS);
  localparam int USED_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int CELLS_W = $clog2(MAX_CELLS + 1);

  localparam int POS_W   = 16;
  localparam int CW_W    = 10;
  localparam int CE_W    = 8;
  localparam int WGT_W   = 18;
  localparam int WID_W   = 17;
  localparam int QUAD_W  = 48;
  localparam int START_W = 10;
  localparam int COUNT_W = 9;

  localparam int WORD_W    = WGT_W + WID_W + QUAD_W + POS_W + START_W;
  localparam int DIV_STEPS = QUAD_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_ROW_LEFT  = 1'b0;
  localparam logic REG_ROW_RIGHT = 1'b1;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_ADD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PLACE,
    S_PRED_RD,
    S_PRED_CMP,
    S_MERGE_MUL,
    S_MERGE,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic mul;
    logic add;
    logic div_start;
    logic place;
    logic pred_rd;
    logic merge_mul;
    logic merge;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic refuse;
    logic div_done;
    logic used_one;
    logic overlap;
  } status_t;

endpackage

@@ rtl/rcl_ram.sv @@
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
module rcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/rcl_div.sv @@
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncating
`timescale 1ns / 1ps
module rcl_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [rcl_pkg::QUAD_W-1:0]    dividend,
  input  logic        [rcl_pkg::WGT_W-1:0]     divisor,
  output logic                                 done,
  output logic signed [rcl_pkg::QUAD_W-1:0]    quotient
);
  import rcl_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic              neg;
  logic [QUAD_W-1:0] mag;
  logic [WGT_W-1:0]  rem;
  logic [WGT_W-1:0]  dvs;
  logic [WGT_W:0]    trial;

  assign trial    = {rem, mag[QUAD_W-1]} - {1'b0, dvs};
  assign done     = busy && (cnt == '0);
  assign quotient = neg ? -$signed(mag) : $signed(mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DCNT_W'(DIV_STEPS);
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[QUAD_W-1];
      mag <= dividend[QUAD_W-1] ? QUAD_W'(-dividend) : QUAD_W'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy && cnt != '0) begin
      // restoring step: keep the trial difference when it did not go negative
      if (!trial[WGT_W]) begin
        rem <= trial[WGT_W-1:0];
        mag <= {mag[QUAD_W-2:0], 1'b1};
      end else begin
        rem <= {rem[WGT_W-2:0], mag[QUAD_W-1]};
        mag <= {mag[QUAD_W-2:0], 1'b0};
      end
    end
  end

endmodule

@@ rtl/rcl_ctrl.sv @@
// controller state machine sequencing checks, divisions and merges
`timescale 1ns / 1ps
module rcl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rcl_pkg::cmd_t     cmd,
  input  rcl_pkg::status_t  status
);
  import rcl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (status.is_clear || status.refuse) begin
          state_next = S_FIN;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        if (status.used_one) begin
          state_next = S_FIN;
        end else begin
          state_next = S_PRED_RD;
        end
      end
      S_PRED_RD: begin
        cmd.pred_rd = 1'b1;
        state_next  = S_PRED_CMP;
      end
      S_PRED_CMP: begin
        if (status.overlap) begin
          state_next = S_MERGE_MUL;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MERGE_MUL: begin
        cmd.merge_mul = 1'b1;
        state_next    = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = S_DIV_GO;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/rcl_datapath.sv @@
// datapath: row registers, top cluster, cluster stack memory, divider and result
`timescale 1ns / 1ps
module rcl_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rcl_pkg::cmd_t                 cmd,
  output rcl_pkg::status_t              status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcl_pkg::PADDR_W-1:0]   paddr,
  input  logic [rcl_pkg::PDATA_W-1:0]   pwdata,
  output logic [rcl_pkg::PDATA_W-1:0]   prdata,
  input  logic                          operation,
  input  logic [rcl_pkg::POS_W-1:0]     wanted_x,
  input  logic [rcl_pkg::CW_W-1:0]      cell_width,
  input  logic [rcl_pkg::CE_W-1:0]      cell_weight,
  output logic                          accepted,
  output logic [rcl_pkg::POS_W-1:0]     placed_x,
  output logic [rcl_pkg::POS_W-1:0]     cluster_x,
  output logic [rcl_pkg::START_W-1:0]   cluster_first_cell,
  output logic [rcl_pkg::COUNT_W-1:0]   cluster_count
);
  import rcl_pkg::*;

  logic [POS_W-1:0] row_left;
  logic [POS_W-1:0] row_right;

  // latched item
  logic             op;
  logic [POS_W-1:0] x_in;
  logic [CW_W-1:0]  w_in;
  logic [CE_W-1:0]  e_in;
  logic             acc;

  // counters
  logic [USED_W-1:0]  used;
  logic [CELLS_W-1:0] cells;
  logic [WID_W-1:0]   width_used;

  // last cluster held in registers, older ones in the stack memory
  logic [WGT_W-1:0]          t_weight;
  logic [WID_W-1:0]          t_width;
  logic signed [QUAD_W-1:0]  t_quad;
  logic [POS_W-1:0]          t_pos;
  logic [START_W-1:0]        t_start;

  logic signed [QUAD_W-1:0]  prod;

  logic [WORD_W-1:0]         wdata;
  logic [WORD_W-1:0]         rdata;
  logic [WGT_W-1:0]          p_weight;
  logic [WID_W-1:0]          p_width;
  logic signed [QUAD_W-1:0]  p_quad;
  logic [POS_W-1:0]          p_pos;
  logic [START_W-1:0]        p_start;

  logic                      fresh;
  logic [POS_W-1:0]          room;
  logic                      push;
  logic [ADDR_W-1:0]         waddr;
  logic [ADDR_W-1:0]         raddr;

  logic                      div_done;
  logic signed [QUAD_W-1:0]  quo;
  logic signed [QUAD_W:0]    p0;
  logic signed [QUAD_W:0]    p1;
  logic signed [QUAD_W:0]    p2;
  logic signed [QUAD_W:0]    p3;
  logic signed [QUAD_W:0]    p4;
  logic signed [QUAD_W:0]    hi;
  logic signed [WID_W:0]     dx;
  logic [WID_W:0]            px_sum;
  logic [WID_W:0]            px;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      row_left  <= '0;
      row_right <= '1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_ROW_LEFT:  row_left  <= pwdata[POS_W-1:0];
        REG_ROW_RIGHT: row_right <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROW_LEFT:  prdata = PDATA_W'(row_left);
      REG_ROW_RIGHT: prdata = PDATA_W'(row_right);
      default:       prdata = '0;
    endcase
  end

  assign room  = (row_right >= row_left) ? row_right - row_left : '0;
  assign fresh = (used == '0) ||
                 ((WID_W + 1)'(t_pos) + (WID_W + 1)'(t_width) <= (WID_W + 1)'(x_in));

  assign status.is_clear = (op == OP_CLEAR);
  assign status.refuse   = ((WID_W + 1)'(width_used) + (WID_W + 1)'(w_in) >
                            (WID_W + 1)'(room)) ||
                           (cells >= CELLS_W'(MAX_CELLS)) ||
                           (fresh && used >= USED_W'(MAX_CLUSTERS));
  assign status.div_done = div_done;
  assign status.used_one = (used == USED_W'(1));
  assign status.overlap  = ((WID_W + 1)'(p_pos) + (WID_W + 1)'(p_width) >
                            (WID_W + 1)'(t_pos));

  // stack memory
  assign push  = cmd.check && !status.is_clear && !status.refuse && fresh && (used != '0);
  assign waddr = ADDR_W'(used - 1'b1);
  assign raddr = ADDR_W'(used - USED_W'(2));
  assign wdata = {t_weight, t_width, t_quad, t_pos, t_start};
  assign {p_weight, p_width, p_quad, p_pos, p_start} = rdata;

  rcl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rcl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (t_quad),
    .divisor  (t_weight),
    .done     (div_done),
    .quotient (quo)
  );

  // clamp of q / e to the segment and to the position range
  assign hi = (QUAD_W + 1)'(row_right) - (QUAD_W + 1)'(t_width);
  assign p0 = (QUAD_W + 1)'(quo);
  assign p1 = (p0 < $signed((QUAD_W + 1)'(row_left))) ? (QUAD_W + 1)'(row_left) : p0;
  assign p2 = (p1 > hi) ? hi : p1;
  assign p3 = (p2 < 0) ? '0 : p2;
  assign p4 = (p3 > $signed((QUAD_W + 1)'(16'hffff))) ? (QUAD_W + 1)'(16'hffff) : p3;

  assign dx = $signed({2'b0, x_in}) - $signed({1'b0, t_width});

  assign px_sum = (WID_W + 1)'(t_pos) + (WID_W + 1)'(t_width);
  assign px     = px_sum - (WID_W + 1)'(w_in);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= operation;
      x_in <= wanted_x;
      w_in <= cell_width;
      e_in <= (cell_weight == '0) ? CE_W'(1) : cell_weight;
    end
    if (cmd.check) begin
      acc <= !status.is_clear && !status.refuse;
      if (!status.is_clear && !status.refuse && fresh) begin
        t_weight <= '0;
        t_width  <= '0;
        t_quad   <= '0;
        t_pos    <= x_in;
        t_start  <= cells[START_W-1:0];
      end
    end
    if (cmd.mul) begin
      prod <= QUAD_W'($signed({1'b0, e_in}) * $signed((WID_W + CE_W + 1)'(dx)));
    end
    if (cmd.add) begin
      t_quad   <= t_quad + prod;
      t_weight <= t_weight + WGT_W'(e_in);
      t_width  <= t_width + WID_W'(w_in);
    end
    if (cmd.place) begin
      t_pos <= p4[POS_W-1:0];
    end
    if (cmd.merge_mul) begin
      prod <= $signed(QUAD_W'((WGT_W + WID_W)'(t_weight) * (WGT_W + WID_W)'(p_width)));
    end
    if (cmd.merge) begin
      t_quad   <= p_quad + t_quad - prod;
      t_weight <= p_weight + t_weight;
      t_width  <= p_width + t_width;
      t_pos    <= p_pos;
      t_start  <= p_start;
    end
    if (cmd.res_load) begin
      accepted           <= acc;
      placed_x           <= acc ? (px[WID_W:POS_W] != '0 ? '1 : px[POS_W-1:0]) : '0;
      cluster_x          <= acc ? t_pos : '0;
      cluster_first_cell <= acc ? t_start : '0;
      cluster_count      <= COUNT_W'(used);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      cells      <= '0;
      width_used <= '0;
    end else begin
      if (cmd.check && status.is_clear) begin
        used       <= '0;
        cells      <= '0;
        width_used <= '0;
      end else if (cmd.check && !status.refuse && fresh) begin
        used <= used + 1'b1;
      end
      if (cmd.add) begin
        cells      <= cells + 1'b1;
        width_used <= width_used + WID_W'(w_in);
      end
      if (cmd.merge) begin
        used <= used - 1'b1;
      end
    end
  end

endmodule

@@ rtl/row_cluster_legalizer_core.sv @@
// top level of the abacus row cluster legalizer
`timescale 1ns / 1ps
// usage
//   input channel (in_valid/in_ready) carries one beat per operation: place a
//   cell (operation 0) or clear the row (operation 1); cells come sorted by x
//   output channel (out_valid/out_ready) returns exactly one beat per input
//   beat, in order, with the placement result or a refusal
//   row_left/row_right are written over the apb port at byte 0 and 4, by
//   the user only while the block is idle (not enforced); pready is tied high
// sequence and throughput
//   clear or refusal: the check state goes straight to the finish state,
//   which loads the result; a placed cell passes multiply, add, divide and
//   place, then, when more than one cluster is used, a predecessor read and
//   compare, plus a multiply, merge and new division per cluster merge;
//   the 48-step bit-serial divider computes q / e; one item is worked at
//   a time; the next input beat is taken once the result sits in the output register
// reset
//   synchronous rst empties the row, sets the segment to 0..65535 and
//   drops out_valid; the cluster stack memory needs no clearing
// stall
//   a held output beat keeps its payload; the block finishes the next item
//   and then waits with it until the output register frees up
module row_cluster_legalizer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcl_pkg::PADDR_W-1:0]   paddr,
  input  logic [rcl_pkg::PDATA_W-1:0]   pwdata,
  output logic [rcl_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [rcl_pkg::POS_W-1:0]     wanted_x,
  input  logic [rcl_pkg::CW_W-1:0]      cell_width,
  input  logic [rcl_pkg::CE_W-1:0]      cell_weight,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          accepted,
  output logic [rcl_pkg::POS_W-1:0]     placed_x,
  output logic [rcl_pkg::POS_W-1:0]     cluster_x,
  output logic [rcl_pkg::START_W-1:0]   cluster_first_cell,
  output logic [rcl_pkg::COUNT_W-1:0]   cluster_count
);
  import rcl_pkg::*;

  cmd_t    cmd;
  status_t status;

  // no wait states on the register port
  assign pready = 1'b1;

  // sequencer: one step of the place/merge flow per state
  rcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // cluster arithmetic, stack memory and result register
  rcl_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .operation          (operation),
    .wanted_x           (wanted_x),
    .cell_width         (cell_width),
    .cell_weight        (cell_weight),
    .accepted           (accepted),
    .placed_x           (placed_x),
    .cluster_x          (cluster_x),
    .cluster_first_cell (cluster_first_cell),
    .cluster_count      (cluster_count)
  );

  // the cluster count never exceeds the stack depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cluster_count <= COUNT_W'(MAX_CLUSTERS))
    else $error("cluster count beyond stack depth");

  // a placed cell sits at or right of its cluster origin
  a_placed_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> placed_x >= cluster_x)
    else $error("placed cell left of its cluster");

  // refused and clear beats carry no position
  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> placed_x == '0 && cluster_x == '0)
    else $error("refusal carries a position");

  // no second input beat is taken while one is in work
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

endmodule

@@ bench/tb_row_cluster_legalizer_core.sv @@
// self-checking testbench for the abacus row cluster legalizer core
`timescale 1ns / 1ps
module tb_row_cluster_legalizer_core;
  import rcl_pkg::*;

  // ---------------------------------------------------------------------------
  // clock, reset and block pins
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid, in_ready;
  logic operation;
  logic [POS_W-1:0] wanted_x;
  logic [CW_W-1:0] cell_width;
  logic [CE_W-1:0] cell_weight;
  logic out_valid, out_ready;
  logic accepted;
  logic [POS_W-1:0] placed_x, cluster_x;
  logic [START_W-1:0] cluster_first_cell;
  logic [COUNT_W-1:0] cluster_count;

  row_cluster_legalizer_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one result beat as the block reports it
  typedef struct packed {
    logic acc;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] cx;
    logic [START_W-1:0] first;
    logic [COUNT_W-1:0] count;
  } placement_t;

  // one row of the directed table; expected values only where they are obvious
  typedef struct {
    logic op;
    logic [POS_W-1:0] x;
    logic [CW_W-1:0] w;
    logic [CE_W-1:0] e;
    bit typed;
    placement_t want;
  } cell_row_t;

  placement_t placements_due[$];
  int fail_count;
  int idle_cycles;
  int items_sent;
  bit quiet;          // no idling on either side while set

  // ---------------------------------------------------------------------------
  // shadow of the row: segment, cluster stack and counters
  // ---------------------------------------------------------------------------
  int unsigned seg_left, seg_right;
  int unsigned cl_weight [MAX_CLUSTERS];
  int unsigned cl_width [MAX_CLUSTERS];
  longint cl_quad [MAX_CLUSTERS];
  int unsigned cl_pos [MAX_CLUSTERS];
  int unsigned cl_start [MAX_CLUSTERS];
  int unsigned n_clusters, n_cells, used_width;

  // optimal spot of cluster k: q / e truncated, clamped to the segment and 16 bits
  function automatic int unsigned best_spot(int unsigned k);
    longint p, hi;
    p = (cl_weight[k] > 0) ? cl_quad[k] / longint'(cl_weight[k]) : longint'(cl_pos[k]);
    hi = longint'(seg_right) - longint'(cl_width[k]);
    if (p < longint'(seg_left)) p = seg_left;
    if (p > hi) p = hi;
    if (p < 0) p = 0;
    if (p > 65535) p = 65535;
    return int'(p);
  endfunction

  // apply one operation to the shadow row and return the result it must give
  function automatic placement_t legalize(logic op, int unsigned x, int unsigned w,
                                          int unsigned e);
    placement_t r;
    int unsigned room, k, pr, px;
    bit fresh;
    r = '0;
    if (op == OP_CLEAR) begin
      n_clusters = 0;
      n_cells = 0;
      used_width = 0;
      return r;
    end
    if (e == 0) e = 1;   // zero weight counts as one
    room = (seg_right >= seg_left) ? seg_right - seg_left : 0;
    fresh = (n_clusters == 0) ||
            (cl_pos[n_clusters-1] + cl_width[n_clusters-1] <= x);
    if (used_width + w > room || n_cells >= MAX_CELLS ||
        (fresh && n_clusters >= MAX_CLUSTERS)) begin
      r.count = n_clusters[COUNT_W-1:0];
      return r;
    end
    if (fresh) begin
      k = n_clusters;
      cl_weight[k] = 0;
      cl_width[k] = 0;
      cl_quad[k] = 0;
      cl_pos[k] = x;
      cl_start[k] = n_cells;
      n_clusters = k + 1;
    end else begin
      k = n_clusters - 1;
    end
    cl_quad[k] += longint'(e) * (longint'(x) - longint'(cl_width[k]));
    cl_weight[k] += e;
    cl_width[k] += w;
    n_cells += 1;
    used_width += w;
    // collapse into predecessors while they overlap
    forever begin
      cl_pos[k] = best_spot(k);
      if (k == 0) break;
      pr = k - 1;
      if (cl_pos[pr] + cl_width[pr] <= cl_pos[k]) break;
      cl_quad[pr] = cl_quad[pr] + cl_quad[k] - longint'(cl_weight[k]) * longint'(cl_width[pr]);
      cl_weight[pr] += cl_weight[k];
      cl_width[pr] += cl_width[k];
      n_clusters = k;
      k = pr;
    end
    px = cl_pos[k] + cl_width[k] - w;
    if (px > 65535) px = 65535;
    r.acc = 1'b1;
    r.px = px[POS_W-1:0];
    r.cx = cl_pos[k][POS_W-1:0];
    r.first = cl_start[k][START_W-1:0];
    r.count = n_clusters[COUNT_W-1:0];
    return r;
  endfunction

  // current cluster count of the shadow row, for a refusal row
  function automatic logic [COUNT_W-1:0] legalize_count();
    return n_clusters[COUNT_W-1:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random back-pressure and the scoreboard
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    placement_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{accepted, placed_x, cluster_x, cluster_first_cell, cluster_count};
        if (placements_due.size() == 0) begin
          $display("unexpected result beat at %0t", $realtime);
          fail_count++;
        end else begin
          want = placements_due.pop_front();
          if (got.acc !== want.acc) report_mismatch("accepted", got.acc, want.acc);
          if (got.px !== want.px) report_mismatch("placed_x", got.px, want.px);
          if (got.cx !== want.cx) report_mismatch("cluster_x", got.cx, want.cx);
          if (got.first !== want.first)
            report_mismatch("cluster_first_cell", got.first, want.first);
          if (got.count !== want.count)
            report_mismatch("cluster_count", got.count, want.count);
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 34);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 60000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input beat; the expectation is formed when the beat is taken
  task automatic send_op(logic op, logic [POS_W-1:0] x, logic [CW_W-1:0] w,
                         logic [CE_W-1:0] e, bit typed = 0, placement_t want = '0);
    placement_t p;
    int gap;
    in_valid <= 1'b1;
    operation <= op;
    wanted_x <= x;
    cell_width <= w;
    cell_weight <= e;
    do @(posedge clk); while (!(in_valid && in_ready));
    p = legalize(op, x, w, e);
    if (typed && p !== want) begin
      $display("directed row disagrees with the row model at %0t", $realtime);
      fail_count++;
    end
    placements_due.insert(placements_due.size(), p);
    items_sent++;
    gap = (!quiet && $urandom_range(99) < 34) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait until every result has come back, then let the block settle
  task automatic drain;
    in_valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(logic idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_ROW_LEFT) seg_left = value & 16'hffff;
    else seg_right = value & 16'hffff;
  endtask

  task automatic apb_check(logic idx, int unsigned want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== want[15:0]) report_mismatch("register readback", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // new segment, written only with the block idle
  task automatic set_segment(int unsigned left, int unsigned right);
    drain();
    apb_write(REG_ROW_LEFT, left);
    apb_write(REG_ROW_RIGHT, right);
    apb_check(REG_ROW_LEFT, left);
    apb_check(REG_ROW_RIGHT, right);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  cell_row_t directed [$];
  int unsigned cur_x, lo, span;
  int pick;

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; operation = OP_PLACE; wanted_x = '0; cell_width = '0;
    cell_weight = '0;
    fail_count = 0; items_sent = 0; quiet = 0;
    seg_left = 0; seg_right = 65535;
    n_clusters = 0; n_cells = 0; used_width = 0;

    // after reset, extremes, zero weight, out of order, clear
    directed = '{
      '{OP_PLACE, 16'd100, 10'd10, 8'd1, 1, '{1'b1, 16'd100, 16'd100, 10'd0, 9'd1}},
      '{OP_CLEAR, 16'd0, 10'd0, 8'd0, 1, '{1'b0, 16'd0, 16'd0, 10'd0, 9'd0}},
      '{OP_PLACE, 16'd100, 10'd10, 8'd1, 1, '{1'b1, 16'd100, 16'd100, 10'd0, 9'd1}},
      '{OP_PLACE, 16'd65535, 10'd1023, 8'd255, 1,
        '{1'b1, 16'd64512, 16'd64512, 10'd1, 9'd2}},
      '{OP_PLACE, 16'd0, 10'd1, 8'd0, 0, '0},
      '{OP_PLACE, 16'd64000, 10'd1023, 8'd255, 0, '0},
      '{OP_PLACE, 16'd64000, 10'd0, 8'd255, 0, '0},
      '{OP_CLEAR, 16'hffff, 10'h3ff, 8'hff, 1, '{1'b0, 16'd0, 16'd0, 10'd0, 9'd0}},
      '{OP_PLACE, 16'd0, 10'd1023, 8'd1, 1, '{1'b1, 16'd0, 16'd0, 10'd0, 9'd1}},
      '{OP_PLACE, 16'd10, 10'd5, 8'd200, 0, '0},
      '{OP_PLACE, 16'd11, 10'd7, 8'd3, 0, '0},
      '{OP_PLACE, 16'd2000, 10'd100, 8'd9, 0, '0},
      '{OP_PLACE, 16'd1500, 10'd600, 8'd255, 0, '0},
      '{OP_PLACE, 16'd40000, 10'd512, 8'd128, 0, '0},
      '{OP_PLACE, 16'h5555, 10'h2aa, 8'h55, 0, '0},
      '{OP_PLACE, 16'haaaa, 10'h155, 8'haa, 0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_op(directed[i].op, directed[i].x, directed[i].w, directed[i].e,
              directed[i].typed, directed[i].want);

    // tiny segment: cells off the left and right edge, refusal for lack of room
    set_segment(1000, 1040);
    send_op(OP_CLEAR, 0, 1, 1);
    send_op(OP_PLACE, 16'd0, 10'd10, 8'd4);
    send_op(OP_PLACE, 16'd60000, 10'd20, 8'd4);
    send_op(OP_PLACE, 16'd60000, 10'd20, 8'd4,
            1, '{1'b0, 16'd0, 16'd0, 10'd0, legalize_count()});
    // inverted segment: no room at all
    set_segment(500, 100);
    send_op(OP_CLEAR, 0, 1, 1);
    send_op(OP_PLACE, 16'd300, 10'd1, 8'd1, 1, '{1'b0, 16'd0, 16'd0, 10'd0, 9'd0});
    // empty segment at the top end
    set_segment(65535, 65535);
    send_op(OP_PLACE, 16'd65535, 10'd1, 8'd1, 1, '{1'b0, 16'd0, 16'd0, 10'd0, 9'd0});

    // cell limit: one ever-growing cluster, then refusals; no idling here
    set_segment(0, 65535);
    quiet = 1;
    send_op(OP_CLEAR, 0, 1, 1);
    repeat (MAX_CELLS + 3) send_op(OP_PLACE, 16'd0, 10'd1, 8'($urandom_range(1, 255)));
    quiet = 0;
    // cluster limit: spaced cells each open a cluster until the stack is full
    send_op(OP_CLEAR, 0, 1, 1);
    for (int i = 0; i < MAX_CLUSTERS + 3; i++)
      send_op(OP_PLACE, 16'(3 * i + 1), 10'd1, 8'($urandom_range(0, 255)));

    // random part: sorted runs with random content, some clears and noise
    while (items_sent < 1850) begin
      if ($urandom_range(99) < 2) begin
        pick = $urandom_range(4);
        lo = $urandom_range(65535);
        case (pick)
          0: set_segment(0, 65535);
          1: set_segment(lo, lo + $urandom_range(0, 3000) > 65535 ? 65535
                                  : lo + $urandom_range(0, 3000));
          2: set_segment(lo, $urandom_range(65535));
          default: begin
            lo = $urandom_range(60000);
            set_segment(lo, lo + $urandom_range(100, 5535));
          end
        endcase
        send_op(OP_CLEAR, 0, 1, 1);
        cur_x = (seg_left > 200) ? seg_left - $urandom_range(200) : 0;
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
        send_op(OP_CLEAR, 16'($urandom), 10'($urandom), 8'($urandom));
        cur_x = (seg_left > 200) ? seg_left - $urandom_range(200) : 0;
      end else if (pick < 10) begin
        send_op(OP_PLACE, 16'($urandom), 10'($urandom), 8'($urandom));
      end else begin
        span = ($urandom_range(3) == 0) ? 60 : 8;
        cur_x += $urandom_range(0, span);
        if (cur_x > 65535) cur_x = 65535;
        send_op(OP_PLACE, 16'(cur_x),
                ($urandom_range(19) == 0) ? 10'($urandom_range(1, 1023))
                                          : 10'($urandom_range(1, 30)),
                8'($urandom_range(0, 255)));
      end
    end

    // let everything come back, then the final word
    in_valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
